@@ src/priority_thread_scheduler_with_join_assert.svh @@
// Assertion macros for the priority thread scheduler.
// Used by priority_thread_scheduler_with_join.sv; expects clk_i and rst_ni in scope.
`ifndef PRIORITY_THREAD_SCHEDULER_WITH_JOIN_ASSERT_SVH
`define PRIORITY_THREAD_SCHEDULER_WITH_JOIN_ASSERT_SVH

// Checked on every clock edge outside reset.
`define PTSJ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, including during reset.
`define PTSJ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ src/ptsj_pkg.sv @@
// Shared types and codes of the priority thread scheduler.
// No dependencies; imported by priority_thread_scheduler_with_join.sv and dv/tb.sv.
package ptsj_pkg;

  typedef enum logic [2:0] {
    CMD_CREATE = 3'd0,
    CMD_YIELD  = 3'd1,
    CMD_JOIN   = 3'd2,
    CMD_EXIT   = 3'd3,
    CMD_START  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    RES_OK       = 3'd0,
    RES_BAD_PRIO = 3'd1,
    RES_TOO_MANY = 3'd2,
    RES_NO_RUN   = 3'd3,
    RES_IDLE     = 3'd4,
    RES_DEADLOCK = 3'd5
  } res_e;

  typedef enum logic {
    REG_FIRST_PID = 1'b0,
    REG_MAX_LIVE  = 1'b1
  } reg_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic [1:0] prio;
    logic [7:0] target_pid;
  } item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] new_pid;
    logic [7:0] run_pid;
    logic       run_valid;
  } result_t;

endpackage

@@ src/priority_thread_scheduler_with_join.sv @@
// Top level of the priority thread scheduler with join.
// Depends on ptsj_pkg and priority_thread_scheduler_with_join_assert.svh.
//
// A command item (create, yield, join, exit, start) is accepted on a clock edge
// where start_i is high and busy_o is low. Exactly one result item follows on
// result_o, marked by done_o for one cycle; the receiver cannot stall it.
// Create, unknown commands, commands refused for lack of a running thread and
// start while a thread runs finish in the accept cycle: done_o rises on the
// next cycle and busy_o stays low, so a new command may follow at once.
// Yield, join, exit and start without a running thread dispatch. Dispatch
// makes one pass over the join list; for each blocked thread it reads the
// thread's entry (S_JRD, S_JCAP), then compares its target pid against every
// slot of the thread table in S_SCAN, one synchronous memory read per cycle.
// It then picks the first nonempty ready queue (S_PICK), reads its head (S_RQ)
// and loads that thread (S_RUN), or reports idle or deadlock; busy_o is high meanwhile.
// Thread pid, level and join target live in one memory; the ready queues live
// in a second memory. Both are written only in the accept cycle or at the end
// of a join check, and read later, so no access to an entry overlaps another.
// Reset empties all queues, frees every slot and clears the running thread;
// no clearing pass is needed. Configuration is written through cfg_we_i while
// the block is idle; writing first_pid restarts pid numbering.
module priority_thread_scheduler_with_join #(
  parameter int MAX_THREADS = 16,
  parameter int NUM_PRIO    = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  ptsj_pkg::item_t  item_i,
  output logic             done_o,
  output ptsj_pkg::result_t result_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [7:0]       cfg_wdata_i
);
  import ptsj_pkg::*;

  localparam int SW    = $clog2(MAX_THREADS);
  localparam int CW    = $clog2(MAX_THREADS + 1);
  localparam int LW    = (NUM_PRIO > 1) ? $clog2(NUM_PRIO) : 1;
  localparam int RQD   = NUM_PRIO * MAX_THREADS;
  localparam int RAW   = (RQD > 1) ? $clog2(RQD) : 1;

  typedef enum logic [1:0] {
    TH_FREE    = 2'd0,
    TH_READY   = 2'd1,
    TH_BLOCKED = 2'd2,
    TH_RUNNING = 2'd3
  } thr_e;

  typedef enum logic [2:0] {
    S_IDLE, S_JRD, S_JCAP, S_SCAN, S_PICK, S_RQ, S_RUN
  } state_e;

  typedef struct packed {
    logic [7:0] pid;
    logic [1:0] level;
    logic [7:0] wait_pid;
  } slot_t;

  // Thread table and ready queue memories.
  slot_t           slot_mem [MAX_THREADS];
  slot_t           slot_rd_q;
  logic [SW-1:0]   rq_mem [RQD];
  logic [SW-1:0]   rq_rd_q;

  state_e          state_q;
  thr_e            stat_q [MAX_THREADS];
  logic [SW-1:0]   jf_q [MAX_THREADS];
  logic [CW-1:0]   jcnt_q, k_q, w_q, c_q, live_q;
  logic [SW-1:0]   head_q [NUM_PRIO];
  logic [CW-1:0]   cnt_q [NUM_PRIO];
  logic            hit_q;
  logic [SW-1:0]   js_q;
  logic [7:0]      jwait_q;
  logic [1:0]      jlvl_q;
  logic [7:0]      last_pid_q;
  logic [4:0]      max_live_q;
  logic [SW-1:0]   run_slot_q;
  logic            run_flag_q;
  logic [7:0]      run_pid_q;
  logic [1:0]      run_lvl_q;
  result_t         res_q;
  logic            done_q;

  // Accept-cycle decode.
  logic            accept, prio_bad, lim_hit, free_found, create_ok, act;
  logic [SW-1:0]   free_idx;
  logic            is_yjx;

  // Dispatch helpers.
  logic [SW-1:0]   cm1;
  logic            cmp, hit_now, fin;
  logic [LW-1:0]   pick;
  logic            pick_any;

  // Enqueue and memory port controls.
  logic            enq_en;
  logic [1:0]      enq_level;
  logic [LW-1:0]   enq_lvl;
  logic [SW-1:0]   enq_slot;
  logic [SW:0]     tail_sum;
  logic [SW-1:0]   tail;
  logic [RAW-1:0]  rq_waddr, rq_raddr;
  logic            slot_we;
  logic [SW-1:0]   slot_waddr, slot_raddr;
  slot_t           slot_wdata;

  assign busy_o   = (state_q != S_IDLE);
  assign accept   = start_i && !busy_o;
  assign is_yjx   = (item_i.cmd == CMD_YIELD) || (item_i.cmd == CMD_JOIN) ||
                    (item_i.cmd == CMD_EXIT);
  assign prio_bad = (item_i.prio == 2'd0) || (int'(item_i.prio) > NUM_PRIO);
  // The limit is the smaller of max_live and the table size.
  assign lim_hit  = (7'(live_q) >= {2'b00, max_live_q}) ||
                    (7'(live_q) >= 7'(MAX_THREADS));

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_THREADS - 1; i >= 0; i--) begin
      if (stat_q[i] == TH_FREE) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  assign create_ok = accept && (item_i.cmd == CMD_CREATE) && !prio_bad && !lim_hit &&
                     free_found;
  assign act       = accept && is_yjx && run_flag_q;

  // A slot matches the join target when it is ready or blocked and has that pid.
  assign cm1     = SW'(c_q - CW'(1));
  assign cmp     = (state_q == S_SCAN) && (c_q != '0) &&
                   ((stat_q[cm1] == TH_READY) || (stat_q[cm1] == TH_BLOCKED)) &&
                   (slot_rd_q.pid == jwait_q);
  assign hit_now = hit_q || cmp;
  assign fin     = (state_q == S_SCAN) && (c_q == CW'(MAX_THREADS));

  always_comb begin
    pick     = '0;
    pick_any = 1'b0;
    for (int i = NUM_PRIO - 1; i >= 0; i--) begin
      if (cnt_q[i] != '0) begin
        pick     = LW'(i);
        pick_any = 1'b1;
      end
    end
  end

  always_comb begin
    enq_en    = 1'b0;
    enq_level = 2'd1;
    enq_slot  = '0;
    if (create_ok) begin
      enq_en    = 1'b1;
      enq_level = item_i.prio;
      enq_slot  = free_idx;
    end else if (act && (item_i.cmd == CMD_YIELD)) begin
      enq_en    = 1'b1;
      enq_level = run_lvl_q;
      enq_slot  = run_slot_q;
    end else if (fin && !hit_now) begin
      enq_en    = 1'b1;
      enq_level = jlvl_q;
      enq_slot  = js_q;
    end
    enq_lvl  = LW'(enq_level - 2'd1);
    tail_sum = (SW + 1)'(head_q[enq_lvl]) + (SW + 1)'(cnt_q[enq_lvl]);
    if (tail_sum >= (SW + 1)'(MAX_THREADS)) begin
      tail_sum = tail_sum - (SW + 1)'(MAX_THREADS);
    end
    tail     = tail_sum[SW-1:0];
    rq_waddr = RAW'(enq_lvl) * RAW'(MAX_THREADS) + RAW'(tail);
    rq_raddr = RAW'(pick) * RAW'(MAX_THREADS) + RAW'(head_q[pick]);
  end

  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = free_idx;
    slot_wdata = '{pid: last_pid_q + 8'd1, level: item_i.prio, wait_pid: 8'd0};
    if (create_ok) begin
      slot_we = 1'b1;
    end else if (act && (item_i.cmd == CMD_JOIN)) begin
      slot_we    = 1'b1;
      slot_waddr = run_slot_q;
      slot_wdata = '{pid: run_pid_q, level: run_lvl_q, wait_pid: item_i.target_pid};
    end
    unique case (state_q)
      S_JRD:   slot_raddr = jf_q[k_q[SW-1:0]];
      S_SCAN:  slot_raddr = c_q[SW-1:0];
      S_RQ:    slot_raddr = rq_rd_q;
      default: slot_raddr = run_slot_q;
    endcase
  end

  // Memories: one write and one registered read per cycle each.
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rd_q <= slot_mem[slot_raddr];
    if (enq_en) begin
      rq_mem[rq_waddr] <= enq_slot;
    end
    rq_rd_q <= rq_mem[rq_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      for (int i = 0; i < MAX_THREADS; i++) begin
        stat_q[i] <= TH_FREE;
        jf_q[i]   <= '0;
      end
      for (int i = 0; i < NUM_PRIO; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      jcnt_q     <= '0;
      k_q        <= '0;
      w_q        <= '0;
      c_q        <= '0;
      live_q     <= '0;
      hit_q      <= 1'b0;
      js_q       <= '0;
      jwait_q    <= '0;
      jlvl_q     <= 2'd1;
      last_pid_q <= 8'd0;
      max_live_q <= 5'd16;
      run_slot_q <= '0;
      run_flag_q <= 1'b0;
      run_pid_q  <= '0;
      run_lvl_q  <= 2'd1;
      res_q      <= '0;
      done_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      res_q  <= '0;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_FIRST_PID: last_pid_q <= cfg_wdata_i;
          REG_MAX_LIVE:  max_live_q <= cfg_wdata_i[4:0];
          default:       ;
        endcase
      end

      if (enq_en) begin
        stat_q[enq_slot] <= TH_READY;
        cnt_q[enq_lvl]   <= cnt_q[enq_lvl] + CW'(1);
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (item_i.cmd == CMD_CREATE) begin
              done_q <= 1'b1;
              if (prio_bad) begin
                res_q.status <= RES_BAD_PRIO;
              end else if (!create_ok) begin
                res_q.status <= RES_TOO_MANY;
              end else begin
                last_pid_q    <= last_pid_q + 8'd1;
                live_q        <= live_q + CW'(1);
                res_q.new_pid <= last_pid_q + 8'd1;
              end
            end else if (is_yjx) begin
              if (!run_flag_q) begin
                done_q       <= 1'b1;
                res_q.status <= RES_NO_RUN;
              end else begin
                run_flag_q <= 1'b0;
                if (item_i.cmd == CMD_JOIN) begin
                  stat_q[run_slot_q] <= TH_BLOCKED;
                  if (jcnt_q < CW'(MAX_THREADS)) begin
                    jf_q[jcnt_q[SW-1:0]] <= run_slot_q;
                    jcnt_q               <= jcnt_q + CW'(1);
                  end
                end else if (item_i.cmd == CMD_EXIT) begin
                  stat_q[run_slot_q] <= TH_FREE;
                  if (live_q != '0) begin
                    live_q <= live_q - CW'(1);
                  end
                end
                k_q     <= '0;
                w_q     <= '0;
                state_q <= S_JRD;
              end
            end else if (item_i.cmd == CMD_START) begin
              if (run_flag_q) begin
                done_q          <= 1'b1;
                res_q.run_pid   <= run_pid_q;
                res_q.run_valid <= 1'b1;
              end else begin
                k_q     <= '0;
                w_q     <= '0;
                state_q <= S_JRD;
              end
            end else begin
              done_q <= 1'b1;
            end
          end
        end
        S_JRD: begin
          if (k_q == jcnt_q) begin
            jcnt_q  <= w_q;
            state_q <= S_PICK;
          end else begin
            js_q    <= jf_q[k_q[SW-1:0]];
            state_q <= S_JCAP;
          end
        end
        S_JCAP: begin
          jwait_q <= slot_rd_q.wait_pid;
          jlvl_q  <= slot_rd_q.level;
          c_q     <= '0;
          hit_q   <= 1'b0;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          hit_q <= hit_now;
          if (fin) begin
            // Still waiting threads are packed toward the front of the list.
            if (hit_now) begin
              jf_q[w_q[SW-1:0]] <= js_q;
              w_q               <= w_q + CW'(1);
            end
            k_q     <= k_q + CW'(1);
            state_q <= S_JRD;
          end else begin
            c_q <= c_q + CW'(1);
          end
        end
        S_PICK: begin
          if (pick_any) begin
            head_q[pick] <= (head_q[pick] == SW'(MAX_THREADS - 1)) ? '0
                                                                     : head_q[pick] + SW'(1);
            cnt_q[pick]  <= cnt_q[pick] - CW'(1);
            state_q      <= S_RQ;
          end else begin
            done_q       <= 1'b1;
            res_q.status <= (jcnt_q != '0) ? RES_DEADLOCK : RES_IDLE;
            state_q      <= S_IDLE;
          end
        end
        S_RQ: begin
          run_slot_q <= rq_rd_q;
          state_q    <= S_RUN;
        end
        S_RUN: begin
          stat_q[run_slot_q] <= TH_RUNNING;
          run_flag_q         <= 1'b1;
          run_pid_q          <= slot_rd_q.pid;
          run_lvl_q          <= slot_rd_q.level;
          done_q             <= 1'b1;
          res_q.run_pid      <= slot_rd_q.pid;
          res_q.run_valid    <= 1'b1;
          state_q            <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

`include "priority_thread_scheduler_with_join_assert.svh"

  `PTSJ_ASSERT(a_run_ok, (done_o && result_o.run_valid) |-> (result_o.status == RES_OK), "dispatched thread with error status")
  `PTSJ_ASSERT(a_run_flag, (done_o && result_o.run_valid) |-> run_flag_q, "reported thread is not running")
  `PTSJ_ASSERT(a_busy_end, $fell(busy_o) |-> done_o, "dispatch ended without a result")
  `PTSJ_ASSERT(a_live_max, live_q <= CW'(MAX_THREADS), "live count above table size")
  `PTSJ_ASSERT(a_join_max, jcnt_q <= CW'(MAX_THREADS), "join list overflow")

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for priority_thread_scheduler_with_join.
// Depends on ptsj_pkg and the scheduler RTL; a scoreboard class predicts each result.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ptsj_pkg::*;

  localparam int NTHR = 16;
  localparam int NLVL = 2;
  localparam logic [1:0] TS_FREE    = 2'd0;
  localparam logic [1:0] TS_READY   = 2'd1;
  localparam logic [1:0] TS_BLOCKED = 2'd2;
  localparam logic [1:0] TS_RUNNING = 2'd3;

  // The scoreboard keeps its own copy of the thread table, the ready queues
  // and the join list, and predicts one result item per accepted command.
  class sched_scoreboard;
    logic [7:0] cfg_first_pid;
    logic [4:0] cfg_max_live;
    logic [7:0] thr_pid[NTHR];
    logic [1:0] thr_lvl[NTHR];
    logic [1:0] thr_state[NTHR];
    logic [7:0] thr_wait[NTHR];
    int         ready_q[NLVL][$];
    int         join_list[$];
    logic [7:0] pid_counter;
    int         run_slot;
    bit         run_flag;
    int         live;
    result_t    pending[$];
    int         errors;
    int         checked;
    int         dispatches;
    int         deadlocks;
    int         joins_released;

    function new();
      errors = 0;
      checked = 0;
      dispatches = 0;
      deadlocks = 0;
      joins_released = 0;
      cfg_first_pid = 8'd0;
      cfg_max_live = 5'd16;
      clear_state();
    endfunction

    function void clear_state();
      for (int s = 0; s < NTHR; s++) begin
        thr_state[s] = TS_FREE;
      end
      for (int l = 0; l < NLVL; l++) begin
        ready_q[l].delete();
      end
      join_list.delete();
      pid_counter = cfg_first_pid;
      run_slot = 0;
      run_flag = 0;
      live = 0;
    endfunction

    function void write_reg(reg_e idx, logic [7:0] val);
      if (idx == REG_FIRST_PID) begin
        cfg_first_pid = val;
        pid_counter = val;
      end else begin
        cfg_max_live = val[4:0];
      end
    endfunction

    function void make_ready(int s);
      ready_q[thr_lvl[s] - 1].push_back(s);
      thr_state[s] = TS_READY;
    endfunction

    function bit pid_waiting_or_ready(logic [7:0] pid);
      for (int s = 0; s < NTHR; s++) begin
        if ((thr_state[s] == TS_READY || thr_state[s] == TS_BLOCKED) && thr_pid[s] == pid)
          return 1;
      end
      return 0;
    endfunction

    // Releases joins in order, each release seen by later entries, then
    // runs the most urgent ready thread, or reports idle or deadlock.
    function void dispatch(ref result_t r);
      int still[$];
      int s;
      dispatches++;
      foreach (join_list[k]) begin
        s = join_list[k];
        if (!pid_waiting_or_ready(thr_wait[s])) begin
          make_ready(s);
          joins_released++;
        end else begin
          still.push_back(s);
        end
      end
      join_list = still;
      for (int l = 0; l < NLVL; l++) begin
        if (ready_q[l].size() > 0) begin
          s = ready_q[l].pop_front();
          thr_state[s] = TS_RUNNING;
          run_slot = s;
          run_flag = 1;
          r.status = RES_OK;
          r.run_pid = thr_pid[s];
          r.run_valid = 1'b1;
          return;
        end
      end
      if (join_list.size() > 0) begin
        r.status = RES_DEADLOCK;
        deadlocks++;
      end else begin
        r.status = RES_IDLE;
      end
    endfunction

    function void note_item(item_t it);
      result_t r;
      int lim, s;
      r = '0;
      case (it.cmd)
        CMD_CREATE: begin
          lim = (cfg_max_live < NTHR) ? cfg_max_live : NTHR;
          s = -1;
          for (int i = NTHR - 1; i >= 0; i--) begin
            if (thr_state[i] == TS_FREE) s = i;
          end
          if (it.prio < 1 || it.prio > NLVL) r.status = RES_BAD_PRIO;
          else if (live >= lim || s < 0) r.status = RES_TOO_MANY;
          else begin
            pid_counter = pid_counter + 8'd1;
            thr_pid[s] = pid_counter;
            thr_lvl[s] = it.prio;
            thr_wait[s] = 8'd0;
            make_ready(s);
            live++;
            r.new_pid = pid_counter;
          end
        end
        CMD_YIELD, CMD_JOIN, CMD_EXIT: begin
          if (!run_flag) r.status = RES_NO_RUN;
          else begin
            run_flag = 0;
            if (it.cmd == CMD_YIELD) make_ready(run_slot);
            else if (it.cmd == CMD_JOIN) begin
              thr_state[run_slot] = TS_BLOCKED;
              thr_wait[run_slot] = it.target_pid;
              join_list.push_back(run_slot);
            end else begin
              thr_state[run_slot] = TS_FREE;
              if (live > 0) live--;
            end
            dispatch(r);
          end
        end
        CMD_START: begin
          if (run_flag) begin
            r.run_pid = thr_pid[run_slot];
            r.run_valid = 1'b1;
          end else begin
            dispatch(r);
          end
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result item %h", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d got %0d", $realtime, want.status, got.status);
        errors++;
      end
      if (got.new_pid !== want.new_pid) begin
        $display("%0t: new_pid expected %0d got %0d", $realtime, want.new_pid, got.new_pid);
        errors++;
      end
      if (got.run_pid !== want.run_pid) begin
        $display("%0t: run_pid expected %0d got %0d", $realtime, want.run_pid, got.run_pid);
        errors++;
      end
      if (got.run_valid !== want.run_valid) begin
        $display("%0t: run_valid expected %0d got %0d", $realtime, want.run_valid,
                 got.run_valid);
        errors++;
      end
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  item_t   cmd_item = '0;
  logic    done;
  result_t result;
  logic    cfg_we = 1'b0;
  logic    cfg_idx = 1'b0;
  logic [7:0] cfg_wdata = '0;

  sched_scoreboard sb = new();
  int idle_pct = 0;
  int sent = 0;

  always #10 clk = ~clk;

  priority_thread_scheduler_with_join dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start_i    (start),
    .busy_o     (busy),
    .item_i     (cmd_item),
    .done_o     (done),
    .result_o   (result),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // Every result is taken at the rising edge that ends its strobe cycle.
  always @(posedge clk) begin
    if (rst_n && done) sb.check_result(result);
  end

  // Drives one command: optional random gap, then start held until accepted.
  // Start stays high across back-to-back items, so it is never dropped and
  // raised again in one step.
  task automatic send_cmd(cmd_e c, logic [1:0] p, logic [7:0] tgt);
    if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    start <= 1'b1;
    cmd_item <= '{cmd: c, prio: p, target_pid: tgt};
    do @(posedge clk); while (busy);
    sb.note_item('{cmd: c, prio: p, target_pid: tgt});
    sent++;
    @(negedge clk);
  endtask

  // Raw version for the unknown command codes, which have no enum name.
  task automatic send_raw(logic [2:0] c, logic [1:0] p, logic [7:0] tgt);
    start <= 1'b1;
    cmd_item <= {c, p, tgt};
    do @(posedge clk); while (busy);
    sb.note_item({c, p, tgt});
    sent++;
    @(negedge clk);
  endtask

  // Lets all expected results arrive, then waits out any work left over.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() > 0) @(negedge clk);
    repeat (8) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_cfg(reg_e idx, logic [7:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // Random command mix that keeps a pool of threads and exercises joins on
  // live pids, absent pids and the running thread's own pid.
  task automatic random_cmd();
    int r;
    logic [7:0] tgt;
    r = $urandom_range(99, 0);
    case ($urandom_range(3, 0))
      0: tgt = sb.pid_counter - 8'($urandom_range(3, 0));
      1: tgt = sb.run_flag ? sb.thr_pid[sb.run_slot] : 8'($urandom);
      default: tgt = 8'($urandom);
    endcase
    if (r < 30) send_cmd(CMD_CREATE, (r < 3) ? 2'($urandom_range(3, 0)) :
                         2'($urandom_range(2, 1)), 8'($urandom));
    else if (r < 52) send_cmd(CMD_YIELD, 2'($urandom), 8'($urandom));
    else if (r < 72) send_cmd(CMD_JOIN, 2'($urandom), tgt);
    else if (r < 87) send_cmd(CMD_EXIT, 2'($urandom), 8'($urandom));
    else if (r < 98) send_cmd(CMD_START, 2'($urandom), 8'($urandom));
    else send_raw(3'($urandom_range(7, 5)), 2'($urandom), 8'($urandom));
  endtask

  // Reset clears the thread table, so the scoreboard does the same through
  // exit commands instead: the block is never reset again mid-run.
  // Threads left in a deadlock stay blocked, so a start that runs nothing ends it.
  task automatic empty_threads();
    int guard;
    guard = 0;
    while (sb.live > 0 && guard < 200) begin
      if (sb.run_flag) send_cmd(CMD_EXIT, 2'd0, 8'd0);
      else begin
        send_cmd(CMD_START, 2'd0, 8'd0);
        if (!sb.run_flag) break;
      end
      guard++;
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part: bad priorities, commands without a running thread,
    // idle start, joins on a waiting pid, on an absent pid and a deadlock.
    send_cmd(CMD_START, 2'd0, 8'd0);
    send_cmd(CMD_YIELD, 2'd0, 8'd0);
    send_cmd(CMD_JOIN, 2'd0, 8'hFF);
    send_cmd(CMD_EXIT, 2'd0, 8'd0);
    send_cmd(CMD_CREATE, 2'd0, 8'd0);
    send_cmd(CMD_CREATE, 2'd3, 8'hFF);
    send_cmd(CMD_CREATE, 2'd2, 8'd0);
    send_cmd(CMD_CREATE, 2'd1, 8'd0);
    send_cmd(CMD_START, 2'd3, 8'hFF);
    send_cmd(CMD_START, 2'd0, 8'd0);
    send_cmd(CMD_YIELD, 2'd0, 8'd0);
    send_cmd(CMD_JOIN, 2'd0, 8'd1);
    send_cmd(CMD_JOIN, 2'd0, 8'd2);
    send_raw(3'd5, 2'd0, 8'd0);
    send_raw(3'd7, 2'd3, 8'hFF);
    send_cmd(CMD_CREATE, 2'd1, 8'd0);
    send_cmd(CMD_START, 2'd0, 8'd0);
    send_cmd(CMD_JOIN, 2'd0, 8'd200);
    send_cmd(CMD_EXIT, 2'd0, 8'd0);
    empty_threads();

    // Limit extremes and pid wrap.
    write_cfg(REG_MAX_LIVE, 8'd0);
    send_cmd(CMD_CREATE, 2'd1, 8'd0);
    write_cfg(REG_MAX_LIVE, 8'd1);
    write_cfg(REG_FIRST_PID, 8'hFE);
    send_cmd(CMD_CREATE, 2'd2, 8'd0);
    send_cmd(CMD_CREATE, 2'd1, 8'd0);
    send_cmd(CMD_START, 2'd0, 8'd0);
    send_cmd(CMD_EXIT, 2'd0, 8'd0);
    send_cmd(CMD_CREATE, 2'd1, 8'd0);
    empty_threads();
    write_cfg(REG_MAX_LIVE, 8'd31);

    // Random phases with different sender gap rates and settings.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 45;
        2: idle_pct = 0;
        default: idle_pct = 14;
      endcase
      if (ph > 0) begin
        empty_threads();
        write_cfg(REG_FIRST_PID, 8'($urandom));
        write_cfg(REG_MAX_LIVE, (ph == 3) ? 8'd16 : 8'($urandom_range(31, 1)));
      end
      repeat (140) random_cmd();
    end
    idle_pct = 0;

    drain();
    repeat (20) @(negedge clk);
    $display("tb: %0d commands, %0d results checked, %0d dispatches, %0d joins released,",
             sent, sb.checked, sb.dispatches, sb.joins_released);
    $display("tb: %0d deadlocks seen, limits from zero to the table size, pid wrap",
             sb.deadlocks);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // About 1300 items, even each with a full join list, stay under 9 ms;
  // the limit is several times that.
  initial begin
    #50ms;
    $display("tb: errors");
    $finish;
  end
endmodule
